@@ rtl/core/bpa_pkg.sv @@
// Shared types, codes and helpers for the bitmap page allocator.
// No dependencies; every other file in rtl/core except bpa_map_ram refers to it by scoped names.
package bpa_pkg;

	localparam int ADDR_W  = 48;
	localparam int BYTES_W = 30;
	localparam int CNT_W   = 18;
	localparam int WORD_BITS = 32;

	localparam logic [ADDR_W-1:0] BASE_RESET = 48'h0000_0010_0000;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_ADD     = 2'd2;
	localparam logic [1:0] CMD_RESERVE = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] addr;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ADDR_W-1:0]  page_address;
		logic [BYTES_W-1:0] free_bytes;
		logic [BYTES_W-1:0] total_bytes;
	} rsp_t;

	// Position of the lowest clear bit of a map word (0 if none is clear).
	function automatic logic [4:0] first_zero(input logic [WORD_BITS-1:0] word);
		logic [4:0] pos;
		pos = 5'd0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				pos = 5'(i);
			end
		end
		return pos;
	endfunction

endpackage

@@ rtl/core/bpa_map_ram.sv @@
// Page map storage: one write port and one read port with registered read data.
// Depends on nothing; the engine drives it through the top level.
module bpa_map_ram #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/bpa_engine.sv @@
// Command sequencer: clearing pass, map scan for alloc, read-modify-write for the
// other commands, and the free and total page counters. Uses bpa_pkg.
module bpa_engine #(
	parameter int PAGE_COUNT = 131072,
	parameter int PAGE_SHIFT = 12,
	parameter int MAP_WORDS  = 4096,
	parameter int WORD_W     = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bpa_pkg::ADDR_W-1:0] base,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bpa_pkg::req_t              req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bpa_pkg::rsp_t              res,
	output logic                       wr_en,
	output logic [WORD_W-1:0]          wr_addr,
	output logic [31:0]                wr_data,
	output logic                       rd_en,
	output logic [WORD_W-1:0]          rd_addr,
	input  logic [31:0]                rd_data
);

	localparam int IX_W = WORD_W + 5;
	localparam int AW = bpa_pkg::ADDR_W;
	localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_LOCATE = 3'd2;
	localparam logic [2:0] S_MODIFY = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0]                   state_q;
	logic [WORD_W-1:0]            word_q;
	logic [1:0]                   cmd_q;
	logic [AW-1:0]                addr_q;
	logic [IX_W-1:0]              idx_q;
	logic [1:0]                   status_q;
	logic [bpa_pkg::CNT_W-1:0]    free_q;
	logic [bpa_pkg::CNT_W-1:0]    total_q;

	// Address to page index.
	logic [AW:0]     offset;
	logic [AW-1:0]   page;
	logic            in_range;

	assign offset   = {1'b0, addr_q} - {1'b0, base};
	assign page     = offset[AW-1:0] >> PAGE_SHIFT;
	assign in_range = !offset[AW] && (page < AW'(PAGE_COUNT));

	// Scan and modify helpers.
	logic [IX_W-1:0] scan_idx;
	logic            word_full;
	logic [31:0]     bit_mask;
	logic            page_used;

	assign scan_idx  = {word_q, bpa_pkg::first_zero(rd_data)};
	assign word_full = (rd_data == '1);
	assign bit_mask  = 32'd1 << idx_q[4:0];
	assign page_used = (rd_data & bit_mask) != '0;

	// Result fields.
	logic [AW-1:0] free_wide;
	logic [AW-1:0] total_wide;
	logic [AW-1:0] page_offset;

	assign free_wide   = AW'(free_q) << PAGE_SHIFT;
	assign total_wide  = AW'(total_q) << PAGE_SHIFT;
	assign page_offset = AW'(idx_q) << PAGE_SHIFT;

	always_comb begin
		res.status       = status_q;
		res.page_address = '0;
		if (cmd_q == bpa_pkg::CMD_ALLOC && status_q == bpa_pkg::ST_DONE) begin
			res.page_address = base + page_offset;
		end
		res.free_bytes  = free_wide[bpa_pkg::BYTES_W-1:0];
		res.total_bytes = total_wide[bpa_pkg::BYTES_W-1:0];
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);

	// Map port drive.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = '1;
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en = req_valid && req.cmd == bpa_pkg::CMD_ALLOC;
			end
			S_LOCATE: begin
				rd_en   = in_range;
				rd_addr = page[IX_W-1:5];
			end
			S_MODIFY: begin
				wr_addr = idx_q[IX_W-1:5];
				if ((cmd_q == bpa_pkg::CMD_FREE || cmd_q == bpa_pkg::CMD_ADD) && page_used) begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~bit_mask;
				end else if (cmd_q == bpa_pkg::CMD_RESERVE && !page_used) begin
					wr_en   = 1'b1;
					wr_data = rd_data | bit_mask;
				end
			end
			S_SCAN: begin
				// Reads run one word ahead of the data being examined.
				rd_en   = word_full && word_q != LAST_WORD;
				rd_addr = word_q + 1'b1;
				if (!word_full && 32'(scan_idx) < 32'(PAGE_COUNT)) begin
					wr_en   = 1'b1;
					wr_data = rd_data | (32'd1 << scan_idx[4:0]);
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			word_q   <= '0;
			free_q   <= '0;
			total_q  <= '0;
			status_q <= bpa_pkg::ST_IGNORED;
			cmd_q    <= bpa_pkg::CMD_ALLOC;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					word_q <= word_q + 1'b1;
					if (word_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q  <= req.cmd;
						addr_q <= req.addr;
						word_q <= '0;
						state_q <= (req.cmd == bpa_pkg::CMD_ALLOC) ? S_SCAN : S_LOCATE;
					end
				end
				S_LOCATE: begin
					idx_q <= page[IX_W-1:0];
					if (in_range) begin
						state_q <= S_MODIFY;
					end else begin
						status_q <= bpa_pkg::ST_IGNORED;
						state_q  <= S_RESP;
					end
				end
				S_MODIFY: begin
					status_q <= bpa_pkg::ST_IGNORED;
					if ((cmd_q == bpa_pkg::CMD_FREE || cmd_q == bpa_pkg::CMD_ADD) && page_used) begin
						status_q <= bpa_pkg::ST_DONE;
						free_q   <= free_q + 1'b1;
						if (cmd_q == bpa_pkg::CMD_ADD && 32'(total_q) < 32'(PAGE_COUNT)) begin
							total_q <= total_q + 1'b1;
						end
					end else if (cmd_q == bpa_pkg::CMD_RESERVE && !page_used) begin
						status_q <= bpa_pkg::ST_DONE;
						if (free_q != '0) begin
							free_q <= free_q - 1'b1;
						end
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (!word_full) begin
						// The first word with a clear bit ends the scan either way.
						idx_q <= scan_idx;
						if (32'(scan_idx) < 32'(PAGE_COUNT)) begin
							status_q <= bpa_pkg::ST_DONE;
							if (free_q != '0) begin
								free_q <= free_q - 1'b1;
							end
						end else begin
							status_q <= bpa_pkg::ST_OOM;
						end
						state_q <= S_RESP;
					end else if (word_q == LAST_WORD) begin
						status_q <= bpa_pkg::ST_OOM;
						state_q  <= S_RESP;
					end else begin
						word_q <= word_q + 1'b1;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/bitmap_page_allocator.sv @@
// Bitmap page allocator, top level: base register, map RAM, command engine and
// the result register. Depends on bpa_pkg, bpa_map_ram and bpa_engine.
//
// One command is handled at a time. After reset the block runs a clearing pass that
// writes every map word to all ones, one word per cycle, and takes no command until it
// is done; base_address writes are taken at any time. Free, add and reserve turn the
// address into a page index and read its map word, write the word back when it
// changes, hand the result to the output register and present it from there; an
// address outside the map skips the read and the write. Alloc reads the map through
// its single read port one word per cycle from page zero and stops at the first word
// with a clear bit or at the last word.
// A finished result sits in an output register, so the next command is accepted
// while the previous result still waits to be taken.
module bitmap_page_allocator #(
	parameter int PAGE_COUNT = 131072,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bpa_pkg::ADDR_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bpa_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output bpa_pkg::rsp_t              rsp
);

	localparam int MAP_WORDS = (PAGE_COUNT + 31) / 32;
	localparam int WORD_W    = $clog2(MAP_WORDS);

	logic [bpa_pkg::ADDR_W-1:0] base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= bpa_pkg::BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	logic              wr_en;
	logic [WORD_W-1:0] wr_addr;
	logic [31:0]       wr_data;
	logic              rd_en;
	logic [WORD_W-1:0] rd_addr;
	logic [31:0]       rd_data;

	bpa_map_ram #(
		.DEPTH  (MAP_WORDS),
		.ADDR_W (WORD_W)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	logic          res_valid;
	logic          res_ready;
	bpa_pkg::rsp_t res;

	bpa_engine #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_SHIFT (PAGE_SHIFT),
		.MAP_WORDS  (MAP_WORDS),
		.WORD_W     (WORD_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.base      (base_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	logic          rsp_valid_q;
	bpa_pkg::rsp_t rsp_q;

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/bpa_checker.sv @@
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator.
module bpa_checker #(
	parameter int PAGE_SHIFT = 12
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bpa_pkg::rsp_t rsp
);

	// A held result beat must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// Commands are handled one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second command taken while one is in progress");

	// Only a successful command may carry an address; status is never the unused code.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == bpa_pkg::ST_DONE || rsp.page_address == '0)
			&& (rsp.status == bpa_pkg::ST_DONE || rsp.status == bpa_pkg::ST_OOM
			|| rsp.status == bpa_pkg::ST_IGNORED))
		else $error("bad status or stray page address");

	// Byte counts are whole pages.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.free_bytes[PAGE_SHIFT-1:0] == '0
			&& rsp.total_bytes[PAGE_SHIFT-1:0] == '0)
		else $error("byte count is not a page multiple");

endmodule

bind bitmap_page_allocator bpa_checker #(
	.PAGE_SHIFT (PAGE_SHIFT)
) u_bpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ tb/sv/tb_bitmap_page_allocator.sv @@
// Self-checking testbench for bitmap_page_allocator: a directed command script, then random
// command streams under several base addresses, with results checked against a local model.
// Depends on bpa_pkg and the bitmap_page_allocator RTL.
module tb_bitmap_page_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_COUNT = 131072;
	localparam int PAGE_SHIFT = 12;
	localparam int MAP_WORDS  = (PAGE_COUNT + 31) / 32;
	localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
	localparam int IDLE_LIMIT = 50000;
	localparam int DRAIN_CYCLES = 16;
	localparam int AW = bpa_pkg::ADDR_W;

	typedef struct packed {
		logic [1:0]    cmd;
		logic [AW-1:0] addr;
		logic          typed;
		bpa_pkg::rsp_t want;
	} script_row_t;

	localparam int SCRIPT_LEN = 19;
	// Rows with typed set carry their own expected beat; the rest use the page map model.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{bpa_pkg::CMD_ALLOC, 48'h0000_0000_0000, 1'b1,
			'{bpa_pkg::ST_OOM, 48'h0, 30'h0, 30'h0}},
		'{bpa_pkg::CMD_FREE, 48'h0000_0000_0000, 1'b1,
			'{bpa_pkg::ST_IGNORED, 48'h0, 30'h0, 30'h0}},
		'{bpa_pkg::CMD_ADD, 48'h0000_0010_0000, 1'b1,
			'{bpa_pkg::ST_DONE, 48'h0, 30'h1000, 30'h1000}},
		'{bpa_pkg::CMD_ADD, 48'h0000_0010_0FFF, 1'b1,
			'{bpa_pkg::ST_IGNORED, 48'h0, 30'h1000, 30'h1000}},
		'{bpa_pkg::CMD_ADD, 48'h0000_2010_0000, 1'b1,
			'{bpa_pkg::ST_IGNORED, 48'h0, 30'h1000, 30'h1000}},
		'{bpa_pkg::CMD_ADD,     48'h0000_200F_FFFF, 1'b0, '0},
		'{bpa_pkg::CMD_RESERVE, 48'h0000_0010_0000, 1'b0, '0},
		'{bpa_pkg::CMD_RESERVE, 48'h0000_0010_0800, 1'b0, '0},
		'{bpa_pkg::CMD_ALLOC,   48'h0000_0000_0000, 1'b0, '0},
		'{bpa_pkg::CMD_ALLOC,   48'hFFFF_FFFF_FFFF, 1'b0, '0},
		'{bpa_pkg::CMD_FREE,    48'h0000_0010_0000, 1'b0, '0},
		'{bpa_pkg::CMD_FREE,    48'h0000_0010_0000, 1'b0, '0},
		'{bpa_pkg::CMD_FREE,    48'h0000_0010_5000, 1'b0, '0},
		'{bpa_pkg::CMD_ALLOC,   48'h0000_0000_0000, 1'b0, '0},
		'{bpa_pkg::CMD_ALLOC,   48'h0000_0000_0000, 1'b0, '0},
		'{bpa_pkg::CMD_ADD,     48'hFFFF_FFFF_FFFF, 1'b0, '0},
		'{bpa_pkg::CMD_RESERVE, 48'h0000_000F_FFFF, 1'b0, '0},
		'{bpa_pkg::CMD_FREE,    48'h0000_200F_FFFF, 1'b0, '0},
		'{bpa_pkg::CMD_RESERVE, 48'h0000_200F_F000, 1'b0, '0}
	};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [AW-1:0] cfg_data = '0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	bpa_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	bpa_pkg::rsp_t rsp;

	// Model state: one bit per page, set when used.
	logic [31:0]               page_words [0:MAP_WORDS-1];
	logic [bpa_pkg::CNT_W-1:0] free_cnt;
	logic [bpa_pkg::CNT_W-1:0] usable_pages;
	logic [AW-1:0]             base_reg;

	bpa_pkg::rsp_t     pending_rsp [$];
	bpa_pkg::rsp_t     head_rsp;
	int                mismatches = 0;
	int                idle_cycles = 0;
	int                burst_left = 0;
	int                stall_mode = 0;
	int                stall_left = 0;

	bitmap_page_allocator #(
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_SHIFT(PAGE_SHIFT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [AW-1:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Applies one command to the page map and returns the beat it should produce.
	function automatic bpa_pkg::rsp_t apply_command(input bpa_pkg::req_t r);
		bpa_pkg::rsp_t     o;
		logic [AW-1:0]     off;
		int unsigned       idx;
		int unsigned       w;
		int unsigned       b;
		bit                found;
		bit                used;
		o = '0;
		o.status = bpa_pkg::ST_IGNORED;
		idx = 0;
		if (r.cmd == bpa_pkg::CMD_ALLOC) begin
			found = 1'b0;
			for (w = 0; w < MAP_WORDS && !found; w++) begin
				if (page_words[w] != '1) begin
					b = 0;
					while (page_words[w][b]) b++;
					idx = w * 32 + b;
					// Later words hold no lower page, so the first open word decides.
					found = (idx < PAGE_COUNT);
					break;
				end
			end
			if (found) begin
				page_words[idx >> 5][idx & 31] = 1'b1;
				if (free_cnt != 0) free_cnt--;
				o.status = bpa_pkg::ST_DONE;
				o.page_address = base_reg + (AW'(idx) << PAGE_SHIFT);
			end else begin
				o.status = bpa_pkg::ST_OOM;
			end
		end else begin
			off = r.addr - base_reg;
			if (r.addr >= base_reg && (off >> PAGE_SHIFT) < PAGE_COUNT) begin
				idx = int'(off >> PAGE_SHIFT);
				used = page_words[idx >> 5][idx & 31];
				if ((r.cmd == bpa_pkg::CMD_FREE || r.cmd == bpa_pkg::CMD_ADD) && used) begin
					page_words[idx >> 5][idx & 31] = 1'b0;
					free_cnt++;
					if (r.cmd == bpa_pkg::CMD_ADD && usable_pages < PAGE_COUNT) usable_pages++;
					o.status = bpa_pkg::ST_DONE;
				end else if (r.cmd == bpa_pkg::CMD_RESERVE && !used) begin
					page_words[idx >> 5][idx & 31] = 1'b1;
					if (free_cnt != 0) free_cnt--;
					o.status = bpa_pkg::ST_DONE;
				end
			end
		end
		o.free_bytes  = bpa_pkg::BYTES_W'(free_cnt) << PAGE_SHIFT;
		o.total_bytes = bpa_pkg::BYTES_W'(usable_pages) << PAGE_SHIFT;
		return o;
	endfunction

	// Mostly pages in a small window above the base, so allocs find them fast; the rest
	// lands at the top of the map, just past it, below the base, or anywhere.
	function automatic bpa_pkg::req_t random_request();
		bpa_pkg::req_t     r;
		int unsigned       pick;
		logic [AW-1:0]     off;
		pick = $urandom_range(0, 99);
		r.cmd = pick < 25 ? bpa_pkg::CMD_ALLOC : pick < 60 ? bpa_pkg::CMD_ADD :
			pick < 85 ? bpa_pkg::CMD_FREE : bpa_pkg::CMD_RESERVE;
		off = AW'($urandom_range(0, PAGE_BYTES - 1));
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			r.addr = base_reg + (AW'($urandom_range(0, 63)) << PAGE_SHIFT) + off;
		end else if (pick < 80) begin
			r.addr = base_reg + (AW'(PAGE_COUNT - 1 - $urandom_range(0, 31)) << PAGE_SHIFT)
				+ off;
		end else if (pick < 87) begin
			r.addr = base_reg + (AW'(PAGE_COUNT + $urandom_range(0, 31)) << PAGE_SHIFT) + off;
		end else if (pick < 93) begin
			r.addr = base_reg - 1 - AW'($urandom_range(0, 65535));
		end else begin
			r.addr = rand48();
		end
		return r;
	endfunction

	task automatic issue(input bpa_pkg::req_t r, input bit typed, input bpa_pkg::rsp_t want);
		int            gap;
		bpa_pkg::rsp_t model_rsp;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		model_rsp = apply_command(r);
		pending_rsp.push_back(typed ? want : model_rsp);
	endtask

	task automatic write_base(input logic [AW-1:0] value);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		base_reg = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [AW-1:0] phase_base [4];
		int            phase_items [4];
		foreach (page_words[i]) page_words[i] = '1;
		free_cnt = '0;
		usable_pages = '0;
		base_reg = bpa_pkg::BASE_RESET;
		phase_base = '{48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, rand48(), rand48()};
		phase_items = '{40, 11, 35, 35};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			issue(bpa_pkg::req_t'{cmd: SCRIPT[i].cmd, addr: SCRIPT[i].addr}, SCRIPT[i].typed,
				SCRIPT[i].want);
		end

		// Pages freed under one base stay free under the next, so allocs after a base
		// change also exercise the 48-bit wrap of the returned address.
		for (int p = 0; p < 4; p++) begin
			write_base(phase_base[p]);
			repeat (phase_items[p]) issue(random_request(), 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("bitmap_page_allocator test passed");
		end else begin
			$display("bitmap_page_allocator test failed");
		end
		$finish;
	end

	// The receiver switches between always ready, coin-flip and mostly stalled stretches.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 1) == 1);
			default: rsp_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("result beat with no command outstanding, status %0d", rsp.status);
				mismatches++;
			end else begin
				head_rsp = pending_rsp.pop_front();
				if (rsp.status !== head_rsp.status) begin
					$error("status: expected %0d, got %0d", head_rsp.status, rsp.status);
					mismatches++;
				end
				if (rsp.page_address !== head_rsp.page_address) begin
					$error("page_address: expected %h, got %h", head_rsp.page_address,
						rsp.page_address);
					mismatches++;
				end
				if (rsp.free_bytes !== head_rsp.free_bytes) begin
					$error("free_bytes: expected %h, got %h", head_rsp.free_bytes, rsp.free_bytes);
					mismatches++;
				end
				if (rsp.total_bytes !== head_rsp.total_bytes) begin
					$error("total_bytes: expected %h, got %h", head_rsp.total_bytes,
						rsp.total_bytes);
					mismatches++;
				end
			end
		end
	end

	// The clearing pass after reset and a full-map alloc scan each run without a beat;
	// the limit leaves room for those plus long receiver stalls.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("bitmap_page_allocator test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
